// ===== design/pic_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, command codes and control structs of the priority interrupt controller
// used by pic_ctrl, pic_datapath and priority_interrupt_controller_top
package pic_pkg;

	localparam int NUM_SOURCES = 64;
	localparam int NUM_IPIS    = 4;
	localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int IPI_W       = (NUM_IPIS > 1) ? $clog2(NUM_IPIS) : 1;
	localparam int SCAN_LANES  = 8;
	localparam int SCAN_CHUNKS = (NUM_SOURCES + SCAN_LANES - 1) / SCAN_LANES;
	localparam int CNT_W       = $clog2(SCAN_CHUNKS + 1);

	localparam logic [31:0] VP_MASK     = 32'h8000_0000;
	localparam logic [31:0] VP_ACTIVITY = 32'h4000_0000;
	localparam int          MASK_BIT    = 31;
	localparam int          SENSE_BIT   = 22;
	localparam int          PRI_LSB     = 16;
	localparam logic [7:0]  SPUR_RESET  = 8'hFF;

	typedef enum logic [3:0] {
		CMD_LINE       = 4'd0,
		CMD_WR_VP      = 4'd1,
		CMD_WR_DEST    = 4'd2,
		CMD_RD_VP      = 4'd3,
		CMD_RD_DEST    = 4'd4,
		CMD_WR_TASK    = 4'd5,
		CMD_RD_TASK    = 4'd6,
		CMD_INTACK     = 4'd7,
		CMD_EOI        = 4'd8,
		CMD_IPI_RAISE  = 4'd9,
		CMD_WR_IPI     = 4'd10,
		CMD_RD_IPI     = 4'd11,
		CMD_SOFT_RESET = 4'd12
	} cmd_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic scan_serv;
		logic rd_issue;
		logic apply;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic scan_last;
	} stat_t;

endpackage

// ===== design/priority_interrupt_controller_top.sv =====
`timescale 1ns / 1ps
// top level of the priority interrupt controller for one cpu
// depends on pic_pkg, pic_ctrl, pic_datapath (and pic_ram below it)

// One word in is one register access; one result word comes out for each, carrying the
// read-back value (or the vector on intack) and cpu_irq as it stands after the access.
// The block works on one word at a time. The priority scanner looks at eight sources a
// cycle and takes the ipis in a final step after the sources. Intack and eoi scan twice
// (before and after the update), every other command scans once; the result may also
// wait on out_stall. A result already waiting in the output register does not hold off
// the next word. Vector/priority and route words sit in rams with a valid bit per entry,
// so reset and soft reset take effect at once.
module priority_interrupt_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [5:0]  target_index,
	input  logic        line_level,
	input  logic [31:0] write_data,
	// result word
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        cpu_irq,
	// spurious vector register
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	pic_pkg::ctl_t  ctl;
	pic_pkg::stat_t stat;

	// sequencer
	pic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// state, scanner and result registers
	pic_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (command),
		.target_index (target_index),
		.line_level   (line_level),
		.write_data   (write_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.read_data    (read_data),
		.cpu_irq      (cpu_irq)
	);

	// an accepted word blocks the input until its result is handed over
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in progress");

	// ram read data is used the cycle after the read is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_issue |=> ctl.apply)
		else $error("update not following ram read");

	// loading the output register always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> out_valid)
		else $error("result loaded but not presented");

endmodule

// ===== design/pic_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module pic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/pic_datapath.sv =====
`timescale 1ns / 1ps
// datapath: source flags, vector/priority and route rams, ipi words, priority scanner
// depends on pic_pkg and pic_ram
module pic_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  pic_pkg::ctl_t   ctl,
	output pic_pkg::stat_t  stat,
	input  logic [3:0]      command,
	input  logic [5:0]      target_index,
	input  logic            line_level,
	input  logic [31:0]     write_data,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	output logic [31:0]     read_data,
	output logic            cpu_irq
);

	localparam int N  = pic_pkg::NUM_SOURCES;
	localparam int NI = pic_pkg::NUM_IPIS;
	localparam int SW = pic_pkg::SRC_W;
	localparam int IW = pic_pkg::IPI_W;
	localparam int CW = pic_pkg::CNT_W;

	// latched word
	pic_pkg::cmd_t cmd_q;
	logic [5:0]    idx_q;
	logic          lvl_q;
	logic [31:0]   data_q;

	// per source flags
	logic       vp_valid_q [N];
	logic       rt_valid_q [N];
	logic       mask_q     [N];
	logic       sense_q    [N];
	logic [3:0] prio_q     [N];
	logic       route0_q   [N];
	logic       line_q     [N];
	logic       pend_q     [N];
	logic       serv_q     [N];

	logic [31:0] ipi_word_q   [NI];
	logic        ipi_raised_q [NI];
	logic [3:0]  task_q;
	logic [7:0]  spur_q;

	// scanner
	logic [CW-1:0] cnt_q;
	logic [4:0]    best_key_q;
	logic [SW-1:0] best_idx_q;
	logic          best_ipi_q;
	logic [IW-1:0] best_ipi_idx_q;
	logic [7:0]    best_vec_q;
	logic [4:0]    nxt_key;
	logic [SW-1:0] nxt_idx;
	logic          nxt_ipi;
	logic [IW-1:0] nxt_ipi_idx;
	logic [7:0]    nxt_vec;

	logic          vp_ok_q, rt_ok_q;
	logic [31:0]   rd_q;
	logic [31:0]   vp_rdata, rt_rdata, vp_word, rt_word;
	logic [SW-1:0] tidx, rd_addr;
	logic [IW-1:0] kidx;
	logic          src_ok, ipi_ok;
	logic          vp_we, rt_we;

	assign tidx    = SW'(idx_q);
	assign kidx    = IW'(idx_q);
	assign src_ok  = int'(idx_q) < N;
	assign ipi_ok  = int'(idx_q) < NI;
	assign rd_addr = (cmd_q == pic_pkg::CMD_INTACK) ? best_idx_q : tidx;
	assign vp_we   = ctl.apply && (cmd_q == pic_pkg::CMD_WR_VP) && src_ok;
	assign rt_we   = ctl.apply && (cmd_q == pic_pkg::CMD_WR_DEST) && src_ok;
	assign vp_word = vp_ok_q ? vp_rdata : pic_pkg::VP_MASK;
	assign rt_word = rt_ok_q ? rt_rdata : 32'd0;
	assign stat.scan_last = (cnt_q == CW'(pic_pkg::SCAN_CHUNKS));

	pic_ram #(.WIDTH(32), .DEPTH(N)) u_vp_ram (
		.clk   (clk),
		.we    (vp_we),
		.waddr (tidx),
		.wdata (data_q & ~pic_pkg::VP_ACTIVITY),
		.raddr (rd_addr),
		.rdata (vp_rdata)
	);

	pic_ram #(.WIDTH(32), .DEPTH(N)) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (tidx),
		.wdata (data_q),
		.raddr (rd_addr),
		.rdata (rt_rdata)
	);

	// one chunk of sources per step, ipis in the final step (not in the serving scan for eoi)
	always_comb begin
		int            pos;
		logic [4:0]    cand;
		logic [SW-1:0] s;
		pos         = 0;
		cand        = '0;
		s           = '0;
		nxt_key     = best_key_q;
		nxt_idx     = best_idx_q;
		nxt_ipi     = best_ipi_q;
		nxt_ipi_idx = best_ipi_idx_q;
		nxt_vec     = best_vec_q;
		if (cnt_q < CW'(pic_pkg::SCAN_CHUNKS)) begin
			for (int j = 0; j < pic_pkg::SCAN_LANES; j++) begin
				pos = int'(cnt_q) * pic_pkg::SCAN_LANES + j;
				if (pos < N) begin
					s = SW'(pos);
					if (ctl.scan_serv) begin
						cand = serv_q[s] ? {1'b1, prio_q[s]} : 5'd0;
					end else begin
						cand = (!mask_q[s] && pend_q[s] && !serv_q[s] && route0_q[s]
							&& (prio_q[s] > task_q)) ? {1'b1, prio_q[s]} : 5'd0;
					end
					if (cand > nxt_key) begin
						nxt_key = cand;
						nxt_idx = s;
						nxt_ipi = 1'b0;
					end
				end
			end
		end else if (!ctl.scan_serv) begin
			for (int k = 0; k < NI; k++) begin
				cand = (!ipi_word_q[k][pic_pkg::MASK_BIT] && ipi_raised_q[k]
					&& (ipi_word_q[k][pic_pkg::PRI_LSB +: 4] > task_q))
					? {1'b1, ipi_word_q[k][pic_pkg::PRI_LSB +: 4]} : 5'd0;
				if (cand > nxt_key) begin
					nxt_key     = cand;
					nxt_ipi     = 1'b1;
					nxt_ipi_idx = IW'(k);
					nxt_vec     = ipi_word_q[k][7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			best_key_q <= '0;
			task_q     <= '0;
			spur_q     <= pic_pkg::SPUR_RESET;
			for (int i = 0; i < N; i++) begin
				vp_valid_q[i] <= 1'b0;
				rt_valid_q[i] <= 1'b0;
				mask_q[i]     <= 1'b1;
				sense_q[i]    <= 1'b0;
				prio_q[i]     <= '0;
				route0_q[i]   <= 1'b0;
				line_q[i]     <= 1'b0;
				pend_q[i]     <= 1'b0;
				serv_q[i]     <= 1'b0;
			end
			for (int k = 0; k < NI; k++) begin
				ipi_word_q[k]   <= '0;
				ipi_raised_q[k] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				spur_q <= cfg_wdata;
			end
			if (ctl.scan_clr) begin
				cnt_q      <= '0;
				best_key_q <= '0;
			end else if (ctl.scan_step) begin
				cnt_q      <= cnt_q + CW'(1);
				best_key_q <= nxt_key;
			end
			if (ctl.apply) begin
				case (cmd_q)
					pic_pkg::CMD_LINE: begin
						if (src_ok) begin
							line_q[tidx] <= lvl_q;
							if (sense_q[tidx]) begin
								pend_q[tidx] <= lvl_q;
							end else if (lvl_q && !line_q[tidx]) begin
								pend_q[tidx] <= 1'b1;
							end
						end
					end
					pic_pkg::CMD_WR_VP: begin
						if (src_ok) begin
							vp_valid_q[tidx] <= 1'b1;
							mask_q[tidx]     <= data_q[pic_pkg::MASK_BIT];
							sense_q[tidx]    <= data_q[pic_pkg::SENSE_BIT];
							prio_q[tidx]     <= data_q[pic_pkg::PRI_LSB +: 4];
						end
					end
					pic_pkg::CMD_WR_DEST: begin
						if (src_ok) begin
							rt_valid_q[tidx] <= 1'b1;
							route0_q[tidx]   <= data_q[0];
						end
					end
					pic_pkg::CMD_WR_TASK: begin
						task_q <= data_q[3:0];
					end
					pic_pkg::CMD_INTACK: begin
						if (best_key_q[4]) begin
							if (best_ipi_q) begin
								ipi_raised_q[best_ipi_idx_q] <= 1'b0;
							end else begin
								serv_q[best_idx_q] <= 1'b1;
								if (!sense_q[best_idx_q]) begin
									pend_q[best_idx_q] <= 1'b0;
								end
							end
						end
					end
					pic_pkg::CMD_EOI: begin
						if (best_key_q[4]) begin
							serv_q[best_idx_q] <= 1'b0;
						end
					end
					pic_pkg::CMD_IPI_RAISE: begin
						if (ipi_ok) begin
							ipi_raised_q[kidx] <= 1'b1;
						end
					end
					pic_pkg::CMD_WR_IPI: begin
						if (ipi_ok) begin
							ipi_word_q[kidx] <= data_q;
						end
					end
					pic_pkg::CMD_SOFT_RESET: begin
						spur_q <= pic_pkg::SPUR_RESET;
						for (int i = 0; i < N; i++) begin
							vp_valid_q[i] <= 1'b0;
							rt_valid_q[i] <= 1'b0;
							mask_q[i]     <= 1'b1;
							sense_q[i]    <= 1'b0;
							prio_q[i]     <= '0;
							route0_q[i]   <= 1'b0;
							line_q[i]     <= 1'b0;
							pend_q[i]     <= 1'b0;
							serv_q[i]     <= 1'b0;
						end
						for (int k = 0; k < NI; k++) begin
							ipi_word_q[k]   <= '0;
							ipi_raised_q[k] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= pic_pkg::cmd_t'(command);
			idx_q  <= target_index;
			lvl_q  <= line_level;
			data_q <= write_data;
		end
		if (ctl.scan_step) begin
			best_idx_q     <= nxt_idx;
			best_ipi_q     <= nxt_ipi;
			best_ipi_idx_q <= nxt_ipi_idx;
			best_vec_q     <= nxt_vec;
		end
		if (ctl.rd_issue) begin
			vp_ok_q <= vp_valid_q[rd_addr];
			rt_ok_q <= rt_valid_q[rd_addr];
		end
		if (ctl.apply) begin
			case (cmd_q)
				pic_pkg::CMD_RD_VP: begin
					rd_q <= src_ok ? (vp_word | (serv_q[tidx] ? pic_pkg::VP_ACTIVITY : 32'd0))
						: 32'd0;
				end
				pic_pkg::CMD_RD_DEST: begin
					rd_q <= src_ok ? rt_word : 32'd0;
				end
				pic_pkg::CMD_RD_TASK: begin
					rd_q <= {28'd0, task_q};
				end
				pic_pkg::CMD_INTACK: begin
					if (!best_key_q[4]) begin
						rd_q <= {24'd0, spur_q};
					end else if (best_ipi_q) begin
						rd_q <= {24'd0, best_vec_q};
					end else begin
						rd_q <= {24'd0, vp_word[7:0]};
					end
				end
				pic_pkg::CMD_RD_IPI: begin
					rd_q <= ipi_ok ? ipi_word_q[kidx] : 32'd0;
				end
				default: begin
					rd_q <= 32'd0;
				end
			endcase
		end
		if (ctl.out_load) begin
			read_data <= rd_q;
			cpu_irq   <= best_key_q[4];
		end
	end

endmodule

// ===== design/pic_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences scan, ram read, update and result hand-off for one word
// depends on pic_pkg
module pic_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [3:0]     command,
	output logic           out_valid,
	input  logic           out_stall,
	input  pic_pkg::stat_t stat,
	output pic_pkg::ctl_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN_A, S_RD, S_APPLY, S_SCAN_B, S_DONE
	} state_t;

	state_t state_q;
	logic   serv_q;
	logic   out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		ctl           = '0;
		ctl.scan_serv = serv_q;
		case (state_q)
			S_IDLE: begin
				ctl.load     = in_valid;
				ctl.scan_clr = in_valid;
			end
			S_SCAN_A: begin
				ctl.scan_step = 1'b1;
			end
			S_RD: begin
				ctl.rd_issue = 1'b1;
			end
			S_APPLY: begin
				ctl.apply    = 1'b1;
				ctl.scan_clr = 1'b1;
			end
			S_SCAN_B: begin
				ctl.scan_step = 1'b1;
				ctl.scan_serv = 1'b0;
			end
			S_DONE: begin
				ctl.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			serv_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						serv_q <= (pic_pkg::cmd_t'(command) == pic_pkg::CMD_EOI);
						if ((pic_pkg::cmd_t'(command) == pic_pkg::CMD_INTACK)
							|| (pic_pkg::cmd_t'(command) == pic_pkg::CMD_EOI)) begin
							state_q <= S_SCAN_A;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_SCAN_A: begin
					if (stat.scan_last) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_SCAN_B;
				end
				S_SCAN_B: begin
					if (stat.scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/priority_interrupt_controller_top_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for priority_interrupt_controller_top
// depends on pic_pkg and the controller rtl; directed and random register accesses
module priority_interrupt_controller_top_test;
	import pic_pkg::*;

	typedef struct packed {
		logic [3:0]  command;
		logic [5:0]  target_index;
		logic        line_level;
		logic [31:0] write_data;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        cpu_irq;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  command;
	logic [5:0]  target_index;
	logic        line_level;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic        cpu_irq;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	priority_interrupt_controller_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.target_index (target_index),
		.line_level   (line_level),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.cpu_irq      (cpu_irq),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// shadow copy of the controller state
	logic [7:0]  shadow_spurious;
	logic [31:0] shadow_vecpri [NUM_SOURCES];
	logic [31:0] shadow_route [NUM_SOURCES];
	logic        shadow_line [NUM_SOURCES];
	logic        shadow_pending [NUM_SOURCES];
	logic        shadow_serving [NUM_SOURCES];
	logic [31:0] shadow_ipi [NUM_IPIS];
	logic        shadow_ipi_raised [NUM_IPIS];
	logic [3:0]  shadow_task;

	access_t pending_words [$];
	answer_t expected_answers [$];
	int      failures;
	int      cycle_count;
	bit      idle_free;      // no random idling while set
	bit      hold_receiver;  // request for a long receiver hold-off
	int      hold_count;

	// timing: settle pause after the queues drain, and the cycle limit of the whole run
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 400000;

	function automatic void clear_shadow();
		for (int i = 0; i < NUM_SOURCES; i++) begin
			shadow_vecpri[i]  = VP_MASK;
			shadow_route[i]   = '0;
			shadow_line[i]    = 1'b0;
			shadow_pending[i] = 1'b0;
			shadow_serving[i] = 1'b0;
		end
		for (int i = 0; i < NUM_IPIS; i++) begin
			shadow_ipi[i]        = '0;
			shadow_ipi_raised[i] = 1'b0;
		end
		shadow_spurious = SPUR_RESET;
	endfunction

	// winner: source index, NUM_SOURCES + ipi number, or -1
	function automatic int find_winner();
		int win;
		int win_pri;
		int p;
		win = -1;
		win_pri = -1;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			p = int'(shadow_vecpri[i][PRI_LSB +: 4]);
			if (!shadow_vecpri[i][MASK_BIT] && shadow_pending[i] && !shadow_serving[i]
					&& shadow_route[i][0] && p > shadow_task && p > win_pri) begin
				win_pri = p;
				win = i;
			end
		end
		for (int i = 0; i < NUM_IPIS; i++) begin
			p = int'(shadow_ipi[i][PRI_LSB +: 4]);
			if (!shadow_ipi[i][MASK_BIT] && shadow_ipi_raised[i] && p > shadow_task
					&& p > win_pri) begin
				win_pri = p;
				win = NUM_SOURCES + i;
			end
		end
		return win;
	endfunction

	function automatic answer_t apply_access(access_t a);
		answer_t res;
		int      w;
		int      best;
		int      top_pri;
		bit      src_ok;
		bit      ipi_ok;
		res = '0;
		src_ok = a.target_index < NUM_SOURCES;
		ipi_ok = a.target_index < NUM_IPIS;
		case (a.command)
			CMD_LINE: if (src_ok) begin
				if (shadow_vecpri[a.target_index][SENSE_BIT])
					shadow_pending[a.target_index] = a.line_level;
				else if (a.line_level && !shadow_line[a.target_index])
					shadow_pending[a.target_index] = 1'b1;
				shadow_line[a.target_index] = a.line_level;
			end
			CMD_WR_VP: if (src_ok) shadow_vecpri[a.target_index] = a.write_data & ~VP_ACTIVITY;
			CMD_WR_DEST: if (src_ok) shadow_route[a.target_index] = a.write_data;
			CMD_RD_VP: if (src_ok)
				res.read_data = shadow_vecpri[a.target_index]
					| (shadow_serving[a.target_index] ? VP_ACTIVITY : 32'h0);
			CMD_RD_DEST: if (src_ok) res.read_data = shadow_route[a.target_index];
			CMD_WR_TASK: shadow_task = a.write_data[3:0];
			CMD_RD_TASK: res.read_data = {28'h0, shadow_task};
			CMD_INTACK: begin
				w = find_winner();
				if (w >= 0 && w < NUM_SOURCES) begin
					res.read_data = {24'h0, shadow_vecpri[w][7:0]};
					shadow_serving[w] = 1'b1;
					if (!shadow_vecpri[w][SENSE_BIT]) shadow_pending[w] = 1'b0;
				end else if (w >= NUM_SOURCES) begin
					res.read_data = {24'h0, shadow_ipi[w - NUM_SOURCES][7:0]};
					shadow_ipi_raised[w - NUM_SOURCES] = 1'b0;
				end else begin
					res.read_data = {24'h0, shadow_spurious};
				end
			end
			CMD_EOI: begin
				best = -1;
				top_pri = -1;
				for (int i = 0; i < NUM_SOURCES; i++)
					if (shadow_serving[i] && int'(shadow_vecpri[i][PRI_LSB +: 4]) > top_pri) begin
						top_pri = int'(shadow_vecpri[i][PRI_LSB +: 4]);
						best = i;
					end
				if (best >= 0) shadow_serving[best] = 1'b0;
			end
			CMD_IPI_RAISE: if (ipi_ok) shadow_ipi_raised[a.target_index] = 1'b1;
			CMD_WR_IPI: if (ipi_ok) shadow_ipi[a.target_index] = a.write_data;
			CMD_RD_IPI: if (ipi_ok) res.read_data = shadow_ipi[a.target_index];
			CMD_SOFT_RESET: clear_shadow();
			default: ;
		endcase
		res.cpu_irq = find_winner() >= 0;
		return res;
	endfunction

	function automatic access_t make_access(logic [3:0] c, int idx, int lvl, logic [31:0] d);
		access_t a;
		a.command = c;
		a.target_index = idx[5:0];
		a.line_level = lvl[0];
		a.write_data = d;
		return a;
	endfunction

	// vecpri word with random content, mostly unmasked
	function automatic logic [31:0] random_vecpri();
		logic [31:0] d;
		d = $urandom;
		if ($urandom_range(0, 3) != 0) d[MASK_BIT] = 1'b0;
		return d;
	endfunction

	// typical interrupt flow with random content
	task automatic queue_random_access();
		int          r;
		int          idx;
		logic [31:0] d;
		r = $urandom_range(0, 99);
		idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
		d = $urandom;
		if (r < 22)
			pending_words.push_back(make_access(CMD_LINE, idx, $urandom_range(0, 1), d));
		else if (r < 32)
			pending_words.push_back(make_access(CMD_WR_VP, idx, $urandom_range(0, 1),
				random_vecpri()));
		else if (r < 38) begin
			if ($urandom_range(0, 2) != 0) d[0] = 1'b1;
			pending_words.push_back(make_access(CMD_WR_DEST, idx, 0, d));
		end else if (r < 44)
			pending_words.push_back(make_access(CMD_RD_VP, idx, 0, d));
		else if (r < 47)
			pending_words.push_back(make_access(CMD_RD_DEST, idx, 0, d));
		else if (r < 51) begin
			if ($urandom_range(0, 1)) d[3:0] = 4'($urandom_range(0, 3));
			pending_words.push_back(make_access(CMD_WR_TASK, idx, 0, d));
		end else if (r < 53)
			pending_words.push_back(make_access(CMD_RD_TASK, idx, 0, d));
		else if (r < 68)
			pending_words.push_back(make_access(CMD_INTACK, idx, 0, d));
		else if (r < 80)
			pending_words.push_back(make_access(CMD_EOI, idx, 0, d));
		else if (r < 86)
			pending_words.push_back(make_access(CMD_IPI_RAISE,
				($urandom_range(0, 7) == 0) ? idx : $urandom_range(0, 3), 0, d));
		else if (r < 91)
			pending_words.push_back(make_access(CMD_WR_IPI,
				($urandom_range(0, 7) == 0) ? idx : $urandom_range(0, 3), 0, random_vecpri()));
		else if (r < 95)
			pending_words.push_back(make_access(CMD_RD_IPI, idx, 0, d));
		else if (r < 97)
			pending_words.push_back(make_access(CMD_SOFT_RESET, idx, 0, d));
		else
			pending_words.push_back(make_access(4'($urandom_range(13, 15)), idx,
				$urandom_range(0, 1), d));
	endtask

	task automatic wait_until_drained();
		while (pending_words.size() != 0 || expected_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// config write while the block sits idle
	task automatic write_spurious(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_spurious = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// driver: presents queued words, predicts each one when it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_answers.push_back(apply_access(pending_words.pop_front()));
			end
			if (!(in_valid && in_stall)) begin
				// next word, or a random idle cycle
				if (pending_words.size() > 0
						&& (idle_free || $urandom_range(0, 99) >= 31)) begin
					in_valid <= 1'b1;
					command <= pending_words[0].command;
					target_index <= pending_words[0].target_index;
					line_level <= pending_words[0].line_level;
					write_data <= pending_words[0].write_data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each result word against the oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$error("result word with no prediction waiting");
					failures <= failures + 1;
				end else begin
					want = expected_answers.pop_front();
					if (read_data !== want.read_data) begin
						$error("read_data expected %h actual %h", want.read_data, read_data);
						failures <= failures + 1;
					end
					if (cpu_irq !== want.cpu_irq) begin
						$error("cpu_irq expected %b actual %b", want.cpu_irq, cpu_irq);
						failures <= failures + 1;
					end
				end
			end
			// long hold-off on request, otherwise random stalls
			if (hold_receiver && hold_count < 400) begin
				out_stall <= 1'b1;
				hold_count <= hold_count + 1;
			end else begin
				out_stall <= !idle_free && $urandom_range(0, 99) < 31;
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = CMD_LINE;
		target_index = '0;
		line_level = 1'b0;
		write_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		failures = 0;
		cycle_count = 0;
		idle_free = 1'b0;
		hold_receiver = 1'b0;
		hold_count = 0;
		shadow_task = '0;
		clear_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: spurious intack at reset, edge and level sources, ties, ipis, eoi
		pending_words.push_back(make_access(CMD_INTACK, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_WR_VP, 5, 0, 32'h4005_0011));
		pending_words.push_back(make_access(CMD_WR_DEST, 5, 0, 32'hFFFF_FFFF));
		pending_words.push_back(make_access(CMD_WR_VP, 2, 0, 32'h0045_0022));
		pending_words.push_back(make_access(CMD_WR_DEST, 2, 0, 32'h1));
		pending_words.push_back(make_access(CMD_LINE, 5, 1, 32'h0));
		pending_words.push_back(make_access(CMD_LINE, 2, 1, 32'h0));
		pending_words.push_back(make_access(CMD_WR_IPI, 3, 0, 32'h7FF5_00AB));
		pending_words.push_back(make_access(CMD_IPI_RAISE, 3, 0, 32'h0));
		pending_words.push_back(make_access(CMD_INTACK, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_RD_VP, 2, 0, 32'h0));
		pending_words.push_back(make_access(CMD_INTACK, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_EOI, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_EOI, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_WR_TASK, 0, 0, 32'hFFFF_FFFF));
		pending_words.push_back(make_access(CMD_RD_TASK, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_WR_VP, 63, 1, 32'hFFFF_FFFF));
		pending_words.push_back(make_access(CMD_RD_VP, 63, 0, 32'h0));
		pending_words.push_back(make_access(CMD_RD_DEST, 63, 0, 32'h0));
		pending_words.push_back(make_access(CMD_WR_IPI, 63, 0, 32'h1234_5678));
		pending_words.push_back(make_access(CMD_RD_IPI, 63, 0, 32'h0));
		pending_words.push_back(make_access(CMD_RD_IPI, 3, 0, 32'h0));
		pending_words.push_back(make_access(4'd15, 1, 1, 32'hFFFF_FFFF));
		pending_words.push_back(make_access(CMD_SOFT_RESET, 0, 0, 32'h0));
		pending_words.push_back(make_access(CMD_INTACK, 0, 0, 32'h0));
		wait_until_drained();

		// random phases with several spurious vector settings, extremes included
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_spurious(8'h00);
				1: write_spurious(8'hFF);
				default: write_spurious(8'($urandom_range(0, 255)));
			endcase
			idle_free = (phase == 2);
			for (i = 0; i < 170; i++) queue_random_access();
			if (phase == 3) begin
				// receiver holds off for a long stretch while words keep coming
				hold_count = 0;
				hold_receiver = 1'b1;
			end
			wait_until_drained();
			hold_receiver = 1'b0;
		end

		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
